[hw/rtl/chip8_instruction_executor_macros.svh]
// Assertion macros used by the checker file.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define C8_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked at every clock edge outside reset.
`define C8_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/c8ie_pkg.sv]
// Package with the shared types and constants of the CHIP-8 executor.
`timescale 1ns / 1ps
package c8ie_pkg;
  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_ROW = 2'd3;
  localparam logic [11:0] PC_RESET = 12'd512;

  typedef struct packed {
    logic [1:0] op;
    logic [15:0] opcode;
    logic [11:0] address;
    logic [7:0] data;
    logic [15:0] keys;
    logic [7:0] random_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pc;
    logic [11:0] index;
    logic [7:0] read_data;
    logic [63:0] display_row;
    logic [7:0] delay_value;
    logic [7:0] sound_value;
    logic waiting_for_key;
    logic error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_MEMRD, ST_MEMWAIT, ST_SPRITE, ST_BCD, ST_STORE,
    ST_LOAD, ST_CLEAR, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_LATCH, CMD_DECODE, CMD_SPRITE_STEP, CMD_BCD_STEP,
    CMD_STORE_STEP, CMD_LOAD_STEP, CMD_CLEAR_STEP
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t code;
    logic mem_issue;
    logic finish;
  } ctrl_cmd_t;

  typedef enum logic [2:0] {
    KIND_SIMPLE, KIND_SPRITE, KIND_BCD, KIND_STORE, KIND_LOAD, KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic last;
  } dp_status_t;
endpackage

[hw/rtl/c8ie_ctrl.sv]
// Controller state machine of the CHIP-8 executor.
`timescale 1ns / 1ps
module c8ie_ctrl (
  input logic clk,
  input logic rst,
  input logic start,
  input c8ie_pkg::dp_status_t status,
  output c8ie_pkg::ctrl_cmd_t cmd,
  output logic busy
);
  import c8ie_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{code: CMD_NONE, mem_issue: 1'b0, finish: 1'b0};
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.code = CMD_LATCH;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.code = CMD_DECODE;
        case (status.kind)
          KIND_SIMPLE: state_next = ST_DONE;
          KIND_CLEAR: state_next = ST_CLEAR;
          KIND_BCD: state_next = ST_BCD;
          KIND_STORE: state_next = ST_STORE;
          default: begin
            cmd.mem_issue = 1'b1;
            state_next = ST_MEMWAIT;
          end
        endcase
      end
      ST_MEMRD: begin
        cmd.mem_issue = 1'b1;
        state_next = ST_MEMWAIT;
      end
      ST_MEMWAIT: begin
        state_next = (status.kind == KIND_SPRITE) ? ST_SPRITE : ST_LOAD;
      end
      ST_SPRITE: begin
        cmd.code = CMD_SPRITE_STEP;
        state_next = status.last ? ST_DONE : ST_MEMRD;
      end
      ST_LOAD: begin
        cmd.code = CMD_LOAD_STEP;
        state_next = status.last ? ST_DONE : ST_MEMRD;
      end
      ST_BCD: begin
        cmd.code = CMD_BCD_STEP;
        if (status.last) state_next = ST_DONE;
      end
      ST_STORE: begin
        cmd.code = CMD_STORE_STEP;
        if (status.last) state_next = ST_DONE;
      end
      ST_CLEAR: begin
        cmd.code = CMD_CLEAR_STEP;
        if (status.last) state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

[hw/rtl/c8ie_datapath.sv]
// Datapath of the CHIP-8 executor: registers, stack, memory and framebuffer.
`timescale 1ns / 1ps
module c8ie_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  input c8ie_pkg::in_item_t item,
  input c8ie_pkg::ctrl_cmd_t cmd,
  output c8ie_pkg::dp_status_t status,
  output c8ie_pkg::out_item_t result,
  output logic done
);
  import c8ie_pkg::*;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  in_item_t cur;
  logic [7:0] vregs [16];
  logic [11:0] index_reg, prog_counter;
  logic [SPW-1:0] stack_ptr;
  logic [11:0] return_stack [STACK_DEPTH];
  logic [7:0] delay_reg, sound_reg;
  logic [7:0] main_memory [4096];
  logic [63:0] framebuffer [32];
  logic [7:0] mem_q;
  logic [11:0] ret_q;
  logic [4:0] step;
  logic hit, waiting, err;
  kind_t kind;

  logic [3:0] x, y, n;
  logic [7:0] nn, vx, vy;
  logic [11:0] nnn, pc2;
  assign x = cur.opcode[11:8];
  assign y = cur.opcode[7:4];
  assign n = cur.opcode[3:0];
  assign nn = cur.opcode[7:0];
  assign nnn = cur.opcode[11:0];
  assign vx = vregs[x];
  assign vy = vregs[y];
  assign pc2 = prog_counter + 12'd2;

  // Step-dependent values.
  logic [11:0] maddr;
  logic [4:0] row;
  logic [5:0] xs;
  logic [63:0] spr;
  assign maddr = index_reg + {7'd0, step};
  assign xs = vx[5:0];
  assign row = vy[4:0] + step;
  assign spr = {mem_q, 56'd0} >> xs;

  // Decimal digits by compare and subtract.
  logic [3:0] hund, tens, ones;
  logic [7:0] rem, ones_full;
  always_comb begin
    hund = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;
    rem = vx - ((vx >= 8'd200) ? 8'd200 : (vx >= 8'd100) ? 8'd100 : 8'd0);
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 8'(k * 10)) tens = 4'(k);
    end
    ones_full = rem - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};
    ones = ones_full[3:0];
  end

  // Simple-instruction decode.
  logic [3:0] fk;
  logic fkf;
  always_comb begin
    fk = 4'd0;
    fkf = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (cur.keys[i]) begin
        fk = 4'(i);
        fkf = 1'b1;
      end
    end
  end

  always_comb begin
    kind = KIND_SIMPLE;
    if (cur.op == OP_EXEC) begin
      if (cur.opcode == 16'h00E0) kind = KIND_CLEAR;
      else if (cur.opcode[15:12] == 4'hD && n != 4'd0) kind = KIND_SPRITE;
      else if (cur.opcode[15:12] == 4'hF && nn == 8'h33) kind = KIND_BCD;
      else if (cur.opcode[15:12] == 4'hF && nn == 8'h55) kind = KIND_STORE;
      else if (cur.opcode[15:12] == 4'hF && nn == 8'h65) kind = KIND_LOAD;
    end
  end

  always_comb begin
    status.kind = kind;
    case (kind)
      KIND_SPRITE: status.last = (5'(step + 5'd1) == {1'b0, n}) || (row == 5'd31);
      KIND_BCD: status.last = (step == 5'd2);
      KIND_CLEAR: status.last = (step == 5'd31);
      default: status.last = (step[3:0] == x);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_issue) mem_q <= main_memory[maddr];
    if (cmd.code == CMD_DECODE && cur.op == OP_WRITE) main_memory[cur.address] <= cur.data;
    if (cmd.code == CMD_BCD_STEP)
      main_memory[maddr] <= {4'd0, (step == 5'd0) ? hund : (step == 5'd1) ? tens : ones};
    if (cmd.code == CMD_STORE_STEP) main_memory[maddr] <= vregs[step[3:0]];
    if (cmd.code == CMD_LATCH) ret_q <= return_stack[SIW'(stack_ptr - SPW'(1))];
    if (cmd.code == CMD_DECODE && cur.op == OP_EXEC && cur.opcode[15:12] == 4'h2
        && stack_ptr < SPW'(STACK_DEPTH))
      return_stack[SIW'(stack_ptr)] <= pc2;
  end

  always_ff @(posedge clk) begin
    if (cmd.code == CMD_LATCH) begin
      cur <= item;
      result.read_data <= 8'd0;
      result.display_row <= 64'd0;
    end
    if (cmd.code == CMD_DECODE && cur.op == OP_READ) result.read_data <= main_memory[cur.address];
    if (cmd.code == CMD_DECODE && cur.op == OP_ROW) result.display_row <= framebuffer[cur.address[4:0]];
    result.pc <= prog_counter;
    result.index <= index_reg;
    result.delay_value <= delay_reg;
    result.sound_value <= sound_reg;
    result.waiting_for_key <= waiting;
    result.error <= err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) vregs[i] <= 8'd0;
      for (int i = 0; i < 32; i++) framebuffer[i] <= 64'd0;
      index_reg <= 12'd0;
      prog_counter <= PC_RESET;
      stack_ptr <= '0;
      delay_reg <= 8'd0;
      sound_reg <= 8'd0;
      step <= 5'd0;
      hit <= 1'b0;
      waiting <= 1'b0;
      err <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      case (cmd.code)
        CMD_LATCH: begin
          step <= 5'd0;
          hit <= 1'b0;
          waiting <= 1'b0;
          err <= 1'b0;
        end
        CMD_DECODE: begin
          if (cur.op == OP_EXEC) begin
            prog_counter <= pc2;
            case (cur.opcode[15:12])
              4'h0: begin
                if (cur.opcode == 16'h00EE) begin
                  if (stack_ptr == '0) begin
                    err <= 1'b1; prog_counter <= prog_counter;
                  end else begin
                    stack_ptr <= stack_ptr - SPW'(1); prog_counter <= ret_q;
                  end
                end else if (cur.opcode != 16'h00E0) begin
                  err <= 1'b1; prog_counter <= prog_counter;
                end
              end
              4'h1: prog_counter <= nnn;
              4'h2: begin
                if (stack_ptr >= SPW'(STACK_DEPTH)) begin
                  err <= 1'b1; prog_counter <= prog_counter;
                end else begin
                  stack_ptr <= stack_ptr + SPW'(1); prog_counter <= nnn;
                end
              end
              4'h3: if (vx == nn) prog_counter <= pc2 + 12'd2;
              4'h4: if (vx != nn) prog_counter <= pc2 + 12'd2;
              4'h5, 4'h9: begin
                if (n != 4'd0) begin
                  err <= 1'b1; prog_counter <= prog_counter;
                end else if ((vx == vy) == (cur.opcode[15:12] == 4'h5)) begin
                  prog_counter <= pc2 + 12'd2;
                end
              end
              4'h6: vregs[x] <= nn;
              4'h7: vregs[x] <= vx + nn;
              4'h8: begin
                case (n)
                  4'h0: vregs[x] <= vy;
                  4'h1: vregs[x] <= vx | vy;
                  4'h2: vregs[x] <= vx & vy;
                  4'h3: vregs[x] <= vx ^ vy;
                  4'h4: begin
                    vregs[x] <= vx + vy; vregs[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
                  end
                  4'h5: begin
                    vregs[x] <= vx - vy; vregs[15] <= {7'd0, vx >= vy};
                  end
                  4'h6: begin
                    vregs[x] <= vx >> 1; vregs[15] <= {7'd0, vx[0]};
                  end
                  4'h7: begin
                    vregs[x] <= vy - vx; vregs[15] <= {7'd0, vy >= vx};
                  end
                  4'hE: begin
                    vregs[x] <= vx << 1; vregs[15] <= {7'd0, vx[7]};
                  end
                  default: begin
                    err <= 1'b1; prog_counter <= prog_counter;
                  end
                endcase
              end
              4'hA: index_reg <= nnn;
              4'hB: prog_counter <= nnn + {4'd0, vx};
              4'hC: vregs[x] <= cur.random_byte & nn;
              4'hD: if (n == 4'd0) vregs[15] <= 8'd0;
              4'hE: begin
                if (nn == 8'h9E) begin
                  if (cur.keys[vx[3:0]]) prog_counter <= pc2 + 12'd2;
                end else if (nn == 8'hA1) begin
                  if (!cur.keys[vx[3:0]]) prog_counter <= pc2 + 12'd2;
                end else begin
                  err <= 1'b1; prog_counter <= prog_counter;
                end
              end
              default: begin
                case (nn)
                  8'h07: vregs[x] <= delay_reg;
                  8'h15: delay_reg <= vx;
                  8'h18: sound_reg <= vx;
                  8'h1E: begin
                    index_reg <= index_reg + {4'd0, vx};
                    vregs[15] <= {7'd0, ({1'b0, index_reg} + {5'd0, vx}) > 13'hFFF};
                  end
                  8'h0A: begin
                    if (fkf) begin
                      vregs[x] <= {4'd0, fk};
                    end else begin
                      prog_counter <= prog_counter; waiting <= 1'b1;
                    end
                  end
                  8'h29: index_reg <= {2'b00, vx, 2'b00} + {4'd0, vx};
                  8'h33, 8'h55, 8'h65: ;
                  default: begin
                    err <= 1'b1; prog_counter <= prog_counter;
                  end
                endcase
              end
            endcase
          end
        end
        CMD_SPRITE_STEP: begin
          framebuffer[row] <= framebuffer[row] ^ spr;
          if (status.last) vregs[15] <= {7'd0, hit | ((framebuffer[row] & spr) != 64'd0)};
          hit <= hit | ((framebuffer[row] & spr) != 64'd0);
          step <= step + 5'd1;
        end
        CMD_LOAD_STEP: begin
          vregs[step[3:0]] <= mem_q;
          step <= step + 5'd1;
        end
        CMD_BCD_STEP, CMD_STORE_STEP: step <= step + 5'd1;
        CMD_CLEAR_STEP: begin
          framebuffer[step] <= 64'd0;
          step <= step + 5'd1;
        end
        default: ;
      endcase
    end
  end
endmodule

[hw/rtl/chip8_instruction_executor.sv]
// A simple op goes from decode straight to the result; BCD writes three digits, a block store
// writes V0 to Vx, a screen clear clears all 32 rows, and sprites and block loads read memory.
// A new transfer can be accepted at the edge that ends the result strobe; the receiver cannot stall.
// Sprite rows and block-load bytes each pass a memory read, a wait state and a step state.
// Reset is synchronous: registers and the screen clear, pc returns to 0x200.
// Memory and return stack contents are undefined until written.
`timescale 1ns / 1ps
module chip8_instruction_executor #(
  parameter int STACK_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  input logic start,
  input c8ie_pkg::in_item_t in_item,
  output logic busy,
  output logic strobe,
  output c8ie_pkg::out_item_t out_item
);
  import c8ie_pkg::*;
  ctrl_cmd_t cmd;
  dp_status_t status;

  c8ie_ctrl u_ctrl (.clk, .rst, .start, .status, .cmd, .busy);
  c8ie_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk, .rst, .item(in_item), .cmd, .status, .result(out_item), .done(strobe)
  );
endmodule

[hw/rtl/c8ie_checker.sv]
// Port-level checker for the CHIP-8 executor and its bind.
`timescale 1ns / 1ps
`include "chip8_instruction_executor_macros.svh"
module c8ie_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input c8ie_pkg::out_item_t out_item
);
  `C8_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `C8_ASSERT_NEXT(a_strobe_pulse, clk, rst, strobe, !strobe)
  `C8_ASSERT_IMP(a_strobe_busy, clk, rst, strobe, !busy)
  `C8_ASSERT_IMP(a_wait_no_err, clk, rst, strobe && out_item.waiting_for_key, !out_item.error)
endmodule

bind chip8_instruction_executor c8ie_checker u_chk (
  .clk, .rst, .start, .busy, .strobe, .out_item
);
